// File: design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared constants, state type and reciprocal table for the integer to text
// converter
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned MAX_DIGITS = 16;
  localparam int unsigned RADIX_BITS = 6;
  localparam int unsigned CHAR_BITS  = 7;
  localparam int unsigned LEN_BITS   = 5;
  localparam int unsigned DIG_BITS   = 6;
  localparam int unsigned IDX_BITS   = $clog2(MAX_DIGITS);
  localparam int unsigned RECIP_BITS = 32;
  localparam int unsigned PROD_BITS  = VALUE_BITS + RECIP_BITS;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] DECIMAL     = 6'd10;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2d;

  localparam logic [63:0] ONE32 = 64'h1_0000_0000;

  // ceil(2^32 / d), exact quotient for any 16-bit dividend
  localparam logic [RECIP_BITS-1:0] RECIP [37] = '{
    32'd0, 32'd0,
    32'((ONE32 + 64'd1)  / 64'd2),  32'((ONE32 + 64'd2)  / 64'd3),
    32'((ONE32 + 64'd3)  / 64'd4),  32'((ONE32 + 64'd4)  / 64'd5),
    32'((ONE32 + 64'd5)  / 64'd6),  32'((ONE32 + 64'd6)  / 64'd7),
    32'((ONE32 + 64'd7)  / 64'd8),  32'((ONE32 + 64'd8)  / 64'd9),
    32'((ONE32 + 64'd9)  / 64'd10), 32'((ONE32 + 64'd10) / 64'd11),
    32'((ONE32 + 64'd11) / 64'd12), 32'((ONE32 + 64'd12) / 64'd13),
    32'((ONE32 + 64'd13) / 64'd14), 32'((ONE32 + 64'd14) / 64'd15),
    32'((ONE32 + 64'd15) / 64'd16), 32'((ONE32 + 64'd16) / 64'd17),
    32'((ONE32 + 64'd17) / 64'd18), 32'((ONE32 + 64'd18) / 64'd19),
    32'((ONE32 + 64'd19) / 64'd20), 32'((ONE32 + 64'd20) / 64'd21),
    32'((ONE32 + 64'd21) / 64'd22), 32'((ONE32 + 64'd22) / 64'd23),
    32'((ONE32 + 64'd23) / 64'd24), 32'((ONE32 + 64'd24) / 64'd25),
    32'((ONE32 + 64'd25) / 64'd26), 32'((ONE32 + 64'd26) / 64'd27),
    32'((ONE32 + 64'd27) / 64'd28), 32'((ONE32 + 64'd28) / 64'd29),
    32'((ONE32 + 64'd29) / 64'd30), 32'((ONE32 + 64'd30) / 64'd31),
    32'((ONE32 + 64'd31) / 64'd32), 32'((ONE32 + 64'd32) / 64'd33),
    32'((ONE32 + 64'd33) / 64'd34), 32'((ONE32 + 64'd34) / 64'd35),
    32'((ONE32 + 64'd35) / 64'd36)
  };

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDig,
    StEmit
  } itoa_state_e;

endpackage

`default_nettype wire

// File: design/integer_to_ascii_radix_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// converts a 16-bit integer to ascii text in a configurable radix (signed in radix 10,
// unsigned otherwise), most significant digit first, one character per output beat
// ----------------------------------------------------------------------------
// the first character is offered in StEmit once every digit has been produced;
// each digit takes a reciprocal multiply (StMul), then the quotient times the base
// gives the remainder digit (StDig)
// input is held off from acceptance until the last character is taken
// reset: control cleared, radix returns to 10; digit buffer is not cleared
`default_nettype none

module integer_to_ascii_radix_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,   // radix
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [6:0] character, [11:7] length, [15:12] zero
  output logic             m_axis_tlast   // last
);

  localparam int unsigned VB = itoa_pkg::VALUE_BITS;
  localparam int unsigned RB = itoa_pkg::RADIX_BITS;
  localparam int unsigned LB = itoa_pkg::LEN_BITS;
  localparam int unsigned DB = itoa_pkg::DIG_BITS;
  localparam int unsigned IB = itoa_pkg::IDX_BITS;
  localparam int unsigned CB = itoa_pkg::CHAR_BITS;
  localparam int unsigned PB = itoa_pkg::PROD_BITS;

  itoa_pkg::itoa_state_e state_q, state_d;

  logic [RB-1:0] radix_q;
  logic [RB-1:0] base_q, base_d;
  logic [itoa_pkg::RECIP_BITS-1:0] recip_q, recip_d;
  logic [VB-1:0] rem_q, rem_d;
  logic [PB-1:0] prod_q, prod_d;
  logic [LB-1:0] cnt_q, cnt_d;
  logic [LB-1:0] total_q, total_d;
  logic          sign_q, sign_d;
  logic [DB-1:0] digit_buf_q [itoa_pkg::MAX_DIGITS];
  logic [DB-1:0] digit_q;

  logic          in_beat;
  logic          out_beat;
  logic [RB-1:0] base_clamp;
  logic          negative;
  logic          use_sign;
  logic [VB-1:0] quot;
  logic [VB+RB-1:0] qd;
  logic [VB-1:0] remainder;
  logic [DB-1:0] digit_wr;
  logic          buf_we;
  logic          rd_ld;
  logic [LB-1:0] cnt_inc;
  logic [LB-1:0] cap;
  logic [LB-1:0] rd_pos;
  logic [LB-1:0] nxt_pos;
  logic [CB-1:0] char_out;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_comb begin
    base_clamp = radix_q;
    if (radix_q < itoa_pkg::RADIX_MIN) begin
      base_clamp = itoa_pkg::RADIX_MIN;
    end else if (radix_q > itoa_pkg::RADIX_MAX) begin
      base_clamp = itoa_pkg::RADIX_MAX;
    end
  end

  assign negative  = s_axis_tdata[VB-1];
  assign use_sign  = (base_clamp == itoa_pkg::DECIMAL) && negative;
  assign quot      = prod_q[PB-1:itoa_pkg::RECIP_BITS];
  assign qd        = {{RB{1'b0}}, quot} * {{VB{1'b0}}, base_q};
  assign remainder = rem_q - qd[VB-1:0];
  assign digit_wr  = remainder[DB-1:0];
  assign cnt_inc   = cnt_q + 5'd1;
  assign cap       = sign_q ? LB'(itoa_pkg::MAX_DIGITS - 1) : LB'(itoa_pkg::MAX_DIGITS);
  assign rd_pos    = cnt_q - 5'd1;
  assign nxt_pos   = cnt_q - 5'd2;

  always_comb begin
    if (digit_q < DB'(10)) begin
      char_out = CB'(digit_q) + itoa_pkg::CHAR_ZERO;
    end else begin
      char_out = CB'(digit_q) - CB'(10) + itoa_pkg::CHAR_A;
    end
  end

  always_comb begin
    state_d       = state_q;
    base_d        = base_q;
    recip_d       = recip_q;
    rem_d         = rem_q;
    prod_d        = prod_q;
    cnt_d         = cnt_q;
    total_d       = total_q;
    sign_d        = sign_q;
    buf_we        = 1'b0;
    rd_ld         = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tlast  = 1'b0;
    m_axis_tdata  = '0;
    case (state_q)
      itoa_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        if (in_beat) begin
          base_d  = base_clamp;
          recip_d = itoa_pkg::RECIP[base_clamp];
          sign_d  = use_sign;
          rem_d   = use_sign ? (VB'(0) - s_axis_tdata) : s_axis_tdata;
          cnt_d   = '0;
          state_d = itoa_pkg::StMul;
        end
      end
      itoa_pkg::StMul: begin
        prod_d  = PB'(rem_q) * PB'(recip_q);
        state_d = itoa_pkg::StDig;
      end
      itoa_pkg::StDig: begin
        buf_we = 1'b1;
        rem_d  = quot;
        cnt_d  = cnt_inc;
        if ((quot != '0) && (cnt_inc < cap)) begin
          state_d = itoa_pkg::StMul;
        end else begin
          total_d = cnt_inc + LB'(sign_q);
          state_d = itoa_pkg::StEmit;
        end
      end
      itoa_pkg::StEmit: begin
        m_axis_tvalid = 1'b1;
        if (sign_q) begin
          m_axis_tdata = {4'b0, total_q, itoa_pkg::CHAR_MINUS};
          m_axis_tlast = (total_q == 5'd1);
        end else begin
          m_axis_tdata = {4'b0, total_q, char_out};
          m_axis_tlast = (cnt_q == 5'd1);
        end
        if (out_beat) begin
          if (sign_q) begin
            sign_d = 1'b0;
          end else begin
            cnt_d = rd_pos;
            if (cnt_q == 5'd1) begin
              state_d = itoa_pkg::StIdle;
            end else begin
              rd_ld = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = itoa_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::StIdle;
      radix_q <= itoa_pkg::RADIX_RESET;
      cnt_q   <= '0;
      sign_q  <= 1'b0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sign_q  <= sign_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    recip_q <= recip_d;
    rem_q   <= rem_d;
    prod_q  <= prod_d;
  end

  // newest digit is the first to leave, later ones are read one beat ahead
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      digit_buf_q[cnt_q[IB-1:0]] <= digit_wr;
      digit_q                    <= digit_wr;
    end else if (rd_ld) begin
      digit_q <= digit_buf_q[nxt_pos[IB-1:0]];
    end
  end

  // input and output never open at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while characters pending");

  // digit count stays within buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LB'(itoa_pkg::MAX_DIGITS))
    else $error("digit count overflow");

  // reciprocal quotient yields a remainder below the base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itoa_pkg::StDig) |-> (remainder < VB'(base_q)))
    else $error("digit out of range");

  // last beat taken returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after last beat");

endmodule

`default_nettype wire

// File: test/tb_integer_to_ascii_radix_core.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_core
// self-checking bench for the integer to text converter: drives signed values
// under several radix settings (clamped ones included) and idle and stall patterns,
// predicts the character beats and checks each one as it is taken
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [6:0] ch;
  logic       last;
  logic [4:0] len;
} text_beat_t;

class text_scoreboard;
  logic [5:0]  radix;
  text_beat_t  chars_due[$];
  int unsigned n_fail;

  function new();
    radix  = itoa_pkg::RADIX_RESET;
    n_fail = 0;
  endfunction

  function void note_value(logic [15:0] value);
    int unsigned base, mag, cnt, cap, total, d;
    bit          sign;
    logic [5:0]  digs [16];
    logic [15:0] magv;
    text_beat_t  beat;
    base = radix;
    if (base < itoa_pkg::RADIX_MIN) base = itoa_pkg::RADIX_MIN;
    if (base > itoa_pkg::RADIX_MAX) base = itoa_pkg::RADIX_MAX;
    sign = (base == itoa_pkg::DECIMAL) && value[15];
    magv = sign ? 16'(16'd0 - value) : value;
    mag  = magv;
    cap  = sign ? itoa_pkg::MAX_DIGITS - 1 : itoa_pkg::MAX_DIGITS;
    cnt  = 0;
    do begin
      digs[cnt] = 6'(mag % base);
      mag = mag / base;
      cnt++;
    end while (mag != 0 && cnt < cap);
    total = cnt + (sign ? 1 : 0);
    if (sign) begin
      beat.ch   = itoa_pkg::CHAR_MINUS;
      beat.last = (total == 1);
      beat.len  = 5'(total);
      chars_due.push_back(beat);
    end
    for (int k = cnt; k > 0; k--) begin
      d = digs[k-1];
      beat.ch   = (d < 10) ? 7'(itoa_pkg::CHAR_ZERO + d) : 7'(itoa_pkg::CHAR_A + d - 10);
      beat.last = (k == 1);
      beat.len  = 5'(total);
      chars_due.push_back(beat);
    end
  endfunction

  function void check_beat(logic [15:0] data, logic last);
    text_beat_t got, want;
    got.ch   = data[6:0];
    got.last = last;
    got.len  = data[11:7];
    if (chars_due.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("unexpected beat: char=%h last=%0d len=%0d", got.ch, got.last, got.len);
      return;
    end
    want = chars_due.pop_front();
    if (got.ch !== want.ch || got.last !== want.last || got.len !== want.len) begin
      n_fail++;
      if (n_fail <= 10)
        $display("mismatch: expected char=%h last=%0d len=%0d, got char=%h last=%0d len=%0d",
                 want.ch, want.last, want.len, got.ch, got.last, got.len);
    end
  endfunction
endclass

module tb_integer_to_ascii_radix_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  text_scoreboard words = new();
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  logic [15:0]    dir_vals[$];

  integer_to_ascii_radix_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      words.check_beat(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_value(input logic [15:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    words.note_value(v);
  endtask

  task automatic send_list();
    foreach (dir_vals[i]) push_value(dir_vals[i]);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (words.chars_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [5:0] r);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    words.radix = r;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(5))
      0, 5: return 16'($urandom);
      1:    return 16'($urandom_range(40));
      2:    return 16'd0 - 16'($urandom_range(40));
      3: begin
        case ($urandom_range(4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'hffff;
          3: return 16'h0000;
          default: return 16'h0001;
        endcase
      end
      default: return 16'((32'd1 << $urandom_range(15)) + $urandom_range(2) - 1);
    endcase
  endfunction

  function automatic logic [5:0] rand_radix();
    case ($urandom_range(3))
      0: return 6'd10;
      1: return 6'($urandom_range(36, 2));
      2: return 6'($urandom_range(63));
      default: begin
        case ($urandom_range(6))
          0: return 6'd2;
          1: return 6'd36;
          2: return 6'd16;
          3: return 6'd0;
          4: return 6'd1;
          5: return 6'd37;
          default: return 6'd63;
        endcase
      end
    endcase
  endfunction

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= 6'd0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= 16'd0;
    m_axis_tready  <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // decimal at reset radix, sign and extremes
    dir_vals = '{16'h0000, 16'h0001, 16'hffff, 16'd9, 16'd10, 16'hfff6,
                 16'h7fff, 16'h8000, 16'hfffb};
    send_list();
    write_radix(6'd2);
    dir_vals = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000};
    send_list();
    write_radix(6'd36);
    dir_vals = '{16'd35, 16'd36, 16'hffff, 16'h8000};
    send_list();
    // negative in hex shows the raw pattern
    write_radix(6'd16);
    dir_vals = '{16'hffff};
    send_list();
    // radix clamping at both ends
    write_radix(6'd0);
    dir_vals = '{16'd5};
    send_list();
    write_radix(6'd1);
    dir_vals = '{16'd6};
    send_list();
    write_radix(6'd63);
    dir_vals = '{16'd35};
    send_list();
    write_radix(6'd37);
    dir_vals = '{16'd36};
    send_list();

    for (int mode = 0; mode < 4; mode++) begin
      wait_drained();
      send_idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 15 : 0;
      recv_stall_pct = (mode == 2) ? 47 : (mode == 3) ? 15 : 0;
      for (int b = 0; b < 4; b++) begin
        write_radix(rand_radix());
        repeat (21) push_value(rand_value());
        s_axis_tvalid <= 1'b0;
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (words.n_fail == 0 && words.chars_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
